// ===== sv/esa_pkg.sv =====
// ----------------------------------------------------------------------------
// esa_pkg: shared types and constants of the slot allocator
// Operation codes, transaction structs and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package esa_pkg;

  localparam int EsaSlotCount = 256;
  localparam int EsaTagBits   = 64;

  localparam logic [2:0] FUNC_ALLOC   = 3'd0;
  localparam logic [2:0] FUNC_SET     = 3'd1;
  localparam logic [2:0] FUNC_ENABLE  = 3'd2;
  localparam logic [2:0] FUNC_DISABLE = 3'd3;
  localparam logic [2:0] FUNC_FREE    = 3'd4;
  localparam logic [2:0] FUNC_QUERY   = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  entity_index;
    logic [63:0] tag_mask;
  } esa_cmd_t;

  typedef struct packed {
    logic [7:0] allocated_index;
    logic       has_all;
    logic [8:0] fresh_count;
    logic       exhausted;
    logic       free_overflow;
  } esa_rsp_t;

  // Operation in the execute stage, as seen by both units
  typedef struct packed {
    logic       valid;
    logic [2:0] func;
    logic [7:0] idx;
    logic       in_range;
  } esa_op_t;

  // Status returned by the free-stack unit
  typedef struct packed {
    logic [7:0] alloc_index;
    logic [8:0] fresh_count;
    logic       exhausted;
    logic       overflow;
  } esa_stack_rsp_t;

endpackage

`default_nettype wire

// ===== sv/esa_ram.sv =====
// ----------------------------------------------------------------------------
// esa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module esa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/esa_tag_unit.sv =====
// ----------------------------------------------------------------------------
// esa_tag_unit: per-slot tag table
// Read at accept, modify and write back in the execute stage, with a
// one-deep bypass and per-entry valid bits that make unwritten slots read 0.
// ----------------------------------------------------------------------------
`default_nettype none

module esa_tag_unit
  import esa_pkg::*;
#(
  parameter int SLOT_COUNT = EsaSlotCount,
  parameter int TAG_BITS   = EsaTagBits
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                issue,
  input  wire logic [7:0]          issue_idx,
  input  wire esa_op_t             op,
  input  wire logic [TAG_BITS-1:0] tags,
  output logic                     has_all
);

  localparam int TblDepth = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
  localparam int Taw      = $clog2(TblDepth);

  logic [TblDepth-1:0] tag_valid;
  logic                byp_valid;
  logic [Taw-1:0]      byp_addr;
  logic [TAG_BITS-1:0] byp_data;

  logic [Taw-1:0]      addr;
  logic [TAG_BITS-1:0] rd_data;
  logic [TAG_BITS-1:0] cur;
  logic                wr_en;
  logic [TAG_BITS-1:0] wr_data;

  assign addr = op.idx[Taw-1:0];

  esa_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (TblDepth)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (issue_idx[Taw-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    // Take the previous write when it hit the same slot
    if (byp_valid && (byp_addr == addr)) begin
      cur = byp_data;
    end else if (op.in_range && tag_valid[addr]) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end

    wr_en   = 1'b0;
    wr_data = cur;
    has_all = 1'b0;
    if (op.valid && op.in_range) begin
      case (op.func)
        FUNC_SET: begin
          wr_en   = 1'b1;
          wr_data = tags;
        end
        FUNC_ENABLE: begin
          wr_en   = 1'b1;
          wr_data = cur | tags;
        end
        FUNC_DISABLE: begin
          wr_en   = 1'b1;
          wr_data = cur & ~tags;
        end
        FUNC_FREE: begin
          wr_en   = 1'b1;
          wr_data = '0;
        end
        FUNC_QUERY: begin
          has_all = ((cur & tags) == tags);
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= '0;
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= wr_en;
      if (wr_en) begin
        tag_valid[addr] <= 1'b1;
      end
    end
    byp_addr <= addr;
    byp_data <= wr_data;
  end

endmodule

`default_nettype wire

// ===== sv/esa_free_stack.sv =====
// ----------------------------------------------------------------------------
// esa_free_stack: LIFO of freed slots and fresh-slot counter
// The top entry is read at accept from the depth the executing transaction
// leaves; a push at that same edge is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module esa_free_stack
  import esa_pkg::*;
#(
  parameter int SLOT_COUNT = EsaSlotCount
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   issue,
  input  wire esa_op_t op,
  output esa_stack_rsp_t status
);

  localparam int Dw  = $clog2(SLOT_COUNT + 1);
  localparam int Saw = $clog2(SLOT_COUNT);

  logic [Dw-1:0] depth;
  logic [Dw-1:0] depth_next;
  logic [Dw-1:0] fresh;
  logic [Dw-1:0] fresh_next;
  logic [Dw-1:0] fresh_sat;
  logic          fwd_valid;
  logic [7:0]    fwd_data;

  logic          is_alloc;
  logic          is_free;
  logic          pop;
  logic          push;
  logic          fresh_path;
  logic [7:0]    rd_data;
  logic [7:0]    popped;
  logic [Dw-1:0] rd_ptr;

  esa_ram #(
    .WIDTH (8),
    .DEPTH (SLOT_COUNT)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (depth[Saw-1:0]),
    .wr_data (op.idx),
    .rd_en   (issue),
    .rd_addr (rd_ptr[Saw-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    is_alloc   = op.valid && (op.func == FUNC_ALLOC);
    is_free    = op.valid && (op.func == FUNC_FREE) && op.in_range;
    pop        = is_alloc && (depth != '0);
    fresh_path = is_alloc && (depth == '0);
    push       = is_free && (depth < Dw'(SLOT_COUNT));

    if (pop) begin
      depth_next = depth - 1'b1;
    end else if (push) begin
      depth_next = depth + 1'b1;
    end else begin
      depth_next = depth;
    end
    rd_ptr = depth_next - 1'b1;

    popped = fwd_valid ? fwd_data : rd_data;

    fresh_sat = (fresh > Dw'(SLOT_COUNT - 1)) ? Dw'(SLOT_COUNT - 1) : fresh;
    if (fresh_path && (fresh < Dw'(SLOT_COUNT))) begin
      fresh_next = fresh + 1'b1;
    end else begin
      fresh_next = fresh;
    end

    if (pop) begin
      status.alloc_index = popped;
    end else if (fresh_path) begin
      status.alloc_index = 8'(fresh_sat);
    end else begin
      status.alloc_index = 8'd0;
    end
    status.fresh_count = 9'(fresh_next);
    status.exhausted   = fresh_path && (fresh_next == Dw'(SLOT_COUNT));
    status.overflow    = is_free && !push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      fresh     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      depth     <= depth_next;
      fresh     <= fresh_next;
      fwd_valid <= push;
    end
    fwd_data <= op.idx;
  end

endmodule

`default_nettype wire

// ===== sv/entity_slot_allocator_with_tags.sv =====
// ----------------------------------------------------------------------------
// entity_slot_allocator_with_tags: slot allocator with per-slot tag masks
// An accepted transaction is registered in the execute stage, then in done.
// Throughput: one transaction every cycle; busy stays low.
// Reset: clears stack depth, fresh counter and tag valid bits at once, so
//   the tag table reads zero straight away; no clearing pass is needed.
// The receiver cannot stall: done is high for one cycle only per result.
// ----------------------------------------------------------------------------
`default_nettype none

module entity_slot_allocator_with_tags
  import esa_pkg::*;
#(
  parameter int SLOT_COUNT = EsaSlotCount,
  parameter int TAG_BITS   = EsaTagBits
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire esa_cmd_t command,
  output logic          done,
  output esa_rsp_t      result
);

  // Execute stage registers
  logic     s1_valid;
  esa_cmd_t s1_cmd;

  logic           accept;
  esa_op_t        op;
  logic           has_all;
  esa_stack_rsp_t stack_status;

  // Every transaction goes through the same stages: never hold off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    op.valid    = s1_valid;
    op.func     = s1_cmd.func;
    op.idx      = s1_cmd.entity_index;
    // Slots past the configured count are ignored
    op.in_range = int'(s1_cmd.entity_index) < SLOT_COUNT;
  end

  // Tag table: read issued at accept, updated in the execute stage
  esa_tag_unit #(
    .SLOT_COUNT (SLOT_COUNT),
    .TAG_BITS   (TAG_BITS)
  ) u_tag_unit (
    .clk       (clk),
    .rst       (rst),
    .issue     (accept),
    .issue_idx (command.entity_index),
    .op        (op),
    .tags      (s1_cmd.tag_mask[TAG_BITS-1:0]),
    .has_all   (has_all)
  );

  // Free stack and fresh counter
  esa_free_stack #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_free_stack (
    .clk    (clk),
    .rst    (rst),
    .issue  (accept),
    .op     (op),
    .status (stack_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      done     <= s1_valid;
    end
    // Capture the transaction and the finished result; payload needs no reset
    if (accept) begin
      s1_cmd <= command;
    end
    if (s1_valid) begin
      result.allocated_index <= stack_status.alloc_index;
      result.has_all         <= has_all;
      result.fresh_count     <= stack_status.fresh_count;
      result.exhausted       <= stack_status.exhausted;
      result.free_overflow   <= stack_status.overflow;
    end
  end

endmodule

`default_nettype wire
